>>> hdl/nes5_pkg.sv
// Shared types and constants for the next even 5-smooth search block.
// Used by nes5_alu and next_even_5_smooth_core; no dependencies of its own.
package nes5_pkg;

  localparam int INT_BITS = 32;
  localparam int TGT_W    = 31;
  localparam int OUT_W    = 31;
  // Growth limit is 2^LIM_SH; working values never exceed three bits above it.
  localparam int LIM_SH   = (INT_BITS - 3 > 61) ? 61 : (INT_BITS - 3);
  localparam int VAL_W    = (LIM_SH + 3 > TGT_W + 1) ? (LIM_SH + 3) : (TGT_W + 1);

  localparam logic [VAL_W-1:0] LIMIT = {{(VAL_W-1){1'b0}}, 1'b1} << LIM_SH;
  localparam logic [VAL_W-1:0] ONE   = {{(VAL_W-1){1'b0}}, 1'b1};
  localparam logic [OUT_W-1:0] SMALL_RESULT = {{(OUT_W-2){1'b0}}, 2'b10};

  typedef enum logic [1:0] {
    OP_DBL  = 2'd0,
    OP_MUL3 = 2'd1,
    OP_MUL5 = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic le_tgt;
    logic lt_tgt;
    logic lt_lim;
  } alu_flags_t;

endpackage

>>> hdl/nes5_alu.sv
// Shared arithmetic unit: scales one operand by 2, 3 or 5 with a single
// shift-and-add, and compares the same operand against the target and limit.
// Depends on nes5_pkg.
module nes5_alu (
  input  nes5_pkg::alu_op_t              op,
  input  logic [nes5_pkg::VAL_W-1:0]     a,
  input  logic [nes5_pkg::VAL_W-1:0]     tgt,
  output logic [nes5_pkg::VAL_W-1:0]     y,
  output nes5_pkg::alu_flags_t           flags
);

  logic [nes5_pkg::VAL_W-1:0] addend;
  logic [nes5_pkg::VAL_W-1:0] shifted;

  always_comb begin
    unique case (op)
      nes5_pkg::OP_DBL: begin
        addend  = '0;
        shifted = a << 1;
      end
      nes5_pkg::OP_MUL3: begin
        addend  = a;
        shifted = a << 1;
      end
      nes5_pkg::OP_MUL5: begin
        addend  = a;
        shifted = a << 2;
      end
      default: begin
        addend  = '0;
        shifted = a << 1;
      end
    endcase
  end

  assign y = addend + shifted;

  assign flags.le_tgt = (a <= tgt);
  assign flags.lt_tgt = (a < tgt);
  assign flags.lt_lim = (a < nes5_pkg::LIMIT);

endmodule

>>> hdl/next_even_5_smooth_core.sv
// Top level of the next even 5-smooth search: sequencer and working registers.
// Depends on nes5_pkg and nes5_alu.
//
// Usage:
//   Raise start with a target on in_target while busy is low; the word is
//   taken at that clock edge. busy then stays high while the search runs.
//   The result appears on out_smooth_value and out_not_found for exactly one
//   cycle, marked by out_strobe, in the same cycle that busy falls; a new start
//   may be given in that same cycle.
//   Targets of 0 or 1 bypass the search: the result (2) appears in the
//   cycle after the start.
//   Otherwise the search walks every odd part 3^b*5^c up to the target and
//   doubles each one, one operation of the shared shift-add unit per cycle.
//   The sequencer checks each power of five in S_OUT, each odd part in S_IN,
//   doubles it in S_DBL until it reaches the target or the growth limit, and
//   steps to the next odd part in S_NXT3 or the next power of five in S_NXT5.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any search in progress without a result. The receiver cannot stall:
//   each result word is valid for its single strobe cycle only.
module next_even_5_smooth_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [nes5_pkg::TGT_W-1:0]    in_target,
  output logic                          out_strobe,
  output logic [nes5_pkg::OUT_W-1:0]    out_smooth_value,
  output logic                          out_not_found
);

  localparam int VW = nes5_pkg::VAL_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_OUT  = 6'b000010,
    S_IN   = 6'b000100,
    S_DBL  = 6'b001000,
    S_NXT3 = 6'b010000,
    S_NXT5 = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0] tgt_r, tgt_nxt;
  logic [VW-1:0] p5_r, p5_nxt;
  logic [VW-1:0] p35_r, p35_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [VW-1:0] best_r, best_nxt;

  logic                       strobe_r, strobe_nxt;
  logic [nes5_pkg::OUT_W-1:0] value_r, value_nxt;
  logic                       nf_r, nf_nxt;

  nes5_pkg::alu_op_t    alu_op;
  logic [VW-1:0]        alu_a;
  logic [VW-1:0]        alu_y;
  nes5_pkg::alu_flags_t alu_flags;

  logic [VW-1:0] in_ext;
  logic          accept;
  logic          better;
  logic          too_wide;

  nes5_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .tgt   (tgt_r),
    .y     (alu_y),
    .flags (alu_flags)
  );

  assign in_ext   = {{(VW - nes5_pkg::TGT_W){1'b0}}, in_target};
  assign accept   = start && (state_r == S_IDLE);
  assign better   = (best_r == '0) || (v_r < best_r);
  assign too_wide = (best_r[VW-1:nes5_pkg::OUT_W] != '0);

  // Each state feeds exactly one working register to the shared unit.
  always_comb begin
    unique case (state_r)
      S_OUT:   begin alu_a = p5_r;  alu_op = nes5_pkg::OP_MUL5; end
      S_IN:    begin alu_a = p35_r; alu_op = nes5_pkg::OP_DBL;  end
      S_DBL:   begin alu_a = v_r;   alu_op = nes5_pkg::OP_DBL;  end
      S_NXT3:  begin alu_a = p35_r; alu_op = nes5_pkg::OP_MUL3; end
      S_NXT5:  begin alu_a = p5_r;  alu_op = nes5_pkg::OP_MUL5; end
      default: begin alu_a = p5_r;  alu_op = nes5_pkg::OP_DBL;  end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    tgt_nxt    = tgt_r;
    p5_nxt     = p5_r;
    p35_nxt    = p35_r;
    v_nxt      = v_r;
    best_nxt   = best_r;
    strobe_nxt = 1'b0;
    value_nxt  = value_r;
    nf_nxt     = nf_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tgt_nxt  = in_ext;
          p5_nxt   = nes5_pkg::ONE;
          best_nxt = '0;
          if (in_target < nes5_pkg::TGT_W'(2)) begin
            strobe_nxt = 1'b1;
            value_nxt  = nes5_pkg::SMALL_RESULT;
            nf_nxt     = 1'b0;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (alu_flags.le_tgt && alu_flags.lt_lim) begin
          p35_nxt   = p5_r;
          state_nxt = S_IN;
        end else begin
          // Search finished: report the best candidate, or a miss.
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
          if (best_r == '0 || too_wide) begin
            value_nxt = '0;
            nf_nxt    = 1'b1;
          end else begin
            value_nxt = best_r[nes5_pkg::OUT_W-1:0];
            nf_nxt    = 1'b0;
          end
        end
      end
      S_IN: begin
        if (alu_flags.le_tgt && alu_flags.lt_lim) begin
          v_nxt     = alu_y;
          state_nxt = S_DBL;
        end else begin
          state_nxt = S_NXT5;
        end
      end
      S_DBL: begin
        if (alu_flags.lt_tgt && alu_flags.lt_lim) begin
          v_nxt = alu_y;
        end else begin
          if (!alu_flags.lt_tgt && better) begin
            best_nxt = v_r;
          end
          state_nxt = S_NXT3;
        end
      end
      S_NXT3: begin
        p35_nxt   = alu_y;
        state_nxt = S_IN;
      end
      S_NXT5: begin
        p5_nxt    = alu_y;
        state_nxt = S_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r   <= tgt_nxt;
    p5_r    <= p5_nxt;
    p35_r   <= p35_nxt;
    v_r     <= v_nxt;
    best_r  <= best_nxt;
    value_r <= value_nxt;
    nf_r    <= nf_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_smooth_value = value_r;
  assign out_not_found    = nf_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word issued while a search is still running");

  a_small_target: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_target < nes5_pkg::TGT_W'(2)) |=>
      out_strobe && (out_smooth_value == nes5_pkg::SMALL_RESULT) && !out_not_found)
    else $error("small target did not give the fixed result next cycle");

  a_even_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_not_found |-> (out_smooth_value[0] == 1'b0) &&
      (out_smooth_value != '0))
    else $error("found result is not a nonzero even value");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_not_found |-> (out_smooth_value == '0))
    else $error("miss reported with a nonzero value");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_target >= nes5_pkg::TGT_W'(2)) |=> busy && !out_strobe)
    else $error("search did not start after a large target was taken");
`endif

endmodule
